/* design/mice_pkg.sv */
package mice_pkg;

  localparam int unsigned InWidth  = 112;
  localparam int unsigned OutWidth = 80;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] INFO_BIAS = 8'd28;
  localparam logic [7:0] SYM_BIAS  = 8'd33;
  localparam logic [8:0] SYM_SHIFT = 9'd63;   // alternate table: code - 33 + 96
  localparam logic [7:0] SYM_MAX   = 8'd189;

  localparam logic [3:0] MSG_EMERGENCY = 4'd0;
  localparam logic [3:0] MSG_STD_BASE  = 4'd8;
  localparam logic [3:0] MSG_CUS_BASE  = 4'd15;
  localparam logic [3:0] MSG_INVALID   = 4'd15;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_STD,
    KIND_CUS,
    KIND_BAD
  } mice_kind_e;

  typedef struct packed {
    logic [47:0] dest;
    logic [47:0] info;
    logic [7:0]  sym_code;
    logic [7:0]  sym_table;
  } mice_in_t;

  typedef struct packed {
    logic [5:0][3:0] digit;
    logic            south;
    logic            offset;
    logic            west;
    logic [3:0]      msg;
    logic            err;
    logic [5:0][7:0] b;
    logic [7:0]      sym;
    logic            overlay;
  } mice_s1_t;

  typedef struct packed {
    logic [6:0] p0;
    logic [6:0] p1;
    logic [6:0] p2;
    logic [7:0] deg;
    logic [5:0] min;
    logic [6:0] hun;
    logic [7:0] b3;
    logic [7:0] b5;
    logic [4:0] q;
    logic [3:0] r;
    logic       south;
    logic       west;
    logic [3:0] msg;
    logic [7:0] sym;
    logic       overlay;
    logic       err;
  } mice_s2_t;

  typedef struct packed {
    logic        err;
    logic        overlay;
    logic [7:0]  sym;
    logic [3:0]  msg;
    logic [9:0]  crs;
    logic [9:0]  spd;
    logic        west;
    logic [6:0]  hun;
    logic [5:0]  min;
    logic [7:0]  deg;
    logic        south;
    logic [19:0] lat;
  } mice_out_t;

  function automatic mice_kind_e mice_char_kind(input logic [7:0] c);
    priority if ((c >= CH_0 && c <= CH_9) || c == CH_L) return KIND_DIGIT;
    else if (c >= CH_P && c <= CH_Z) return KIND_STD;
    else if (c >= CH_A && c <= CH_K) return KIND_CUS;
    else return KIND_BAD;
  endfunction

  function automatic logic [3:0] mice_char_digit(input logic [7:0] c, input mice_kind_e k);
    logic [7:0] d;
    unique case (k)
      KIND_DIGIT: d = (c == CH_L) ? 8'd0 : c - CH_0;
      KIND_STD:   d = c - CH_P;
      KIND_CUS:   d = c - CH_A;
      default:    d = 8'd0;
    endcase
    // Z and K land on ten and wrap to zero
    if (d >= 8'd10) d = d - 8'd10;
    return d[3:0];
  endfunction

endpackage

/* design/mice_classify.sv */
module mice_classify import mice_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  mice_in_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output mice_s1_t data_o
);

  logic     valid_q;
  mice_s1_t data_q, data_d;
  mice_kind_e [5:0] kind;

  always_comb begin
    logic [7:0] ch;
    logic [7:0] v;
    logic       std_seen, cus_seen, bad_seen;
    logic [2:0] bits;
    data_d = '0;
    for (int i = 0; i < 6; i++) begin
      ch = data_i.dest[8*(5-i) +: 8];
      kind[i] = mice_char_kind(ch);
      data_d.digit[i] = mice_char_digit(ch, kind[i]);
      if (kind[i] == KIND_BAD) data_d.err = 1'b1;
      if (i >= 3 && kind[i] == KIND_CUS) data_d.err = 1'b1;
    end
    data_d.south  = (kind[3] == KIND_DIGIT) || (kind[3] == KIND_CUS);
    data_d.offset = (kind[4] == KIND_STD);
    data_d.west   = (kind[5] == KIND_STD);

    // message bits: first character is the most significant
    std_seen = (kind[0] == KIND_STD) || (kind[1] == KIND_STD) || (kind[2] == KIND_STD);
    cus_seen = (kind[0] == KIND_CUS) || (kind[1] == KIND_CUS) || (kind[2] == KIND_CUS);
    bad_seen = (kind[0] == KIND_BAD) || (kind[1] == KIND_BAD) || (kind[2] == KIND_BAD);
    bits = {(kind[0] == KIND_STD) || (kind[0] == KIND_CUS),
            (kind[1] == KIND_STD) || (kind[1] == KIND_CUS),
            (kind[2] == KIND_STD) || (kind[2] == KIND_CUS)};
    priority if (bad_seen || (std_seen && cus_seen)) data_d.msg = MSG_INVALID;
    else if (bits == 3'd0) data_d.msg = MSG_EMERGENCY;
    else if (std_seen) data_d.msg = MSG_STD_BASE - 4'(bits);
    else data_d.msg = MSG_CUS_BASE - 4'(bits);

    // remove the info byte bias, low bytes count as zero
    for (int i = 0; i < 6; i++) begin
      v = data_i.info[8*(5-i) +: 8];
      if (v < INFO_BIAS) begin
        data_d.err = 1'b1;
        data_d.b[i] = 8'd0;
      end else begin
        data_d.b[i] = v - INFO_BIAS;
      end
    end

    if (data_i.sym_table == CH_SLASH) begin
      if (data_i.sym_code < SYM_BIAS) data_d.sym = 8'd0;
      else if (data_i.sym_code - SYM_BIAS > SYM_MAX) data_d.sym = SYM_MAX;
      else data_d.sym = data_i.sym_code - SYM_BIAS;
    end else begin
      if (9'(data_i.sym_code) + SYM_SHIFT > 9'(SYM_MAX)) data_d.sym = SYM_MAX;
      else data_d.sym = 8'(9'(data_i.sym_code) + SYM_SHIFT);
    end
    data_d.overlay = (data_i.sym_table != CH_SLASH) && (data_i.sym_table != CH_BSLASH);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/mice_combine.sv */
module mice_combine import mice_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  mice_s1_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output mice_s2_t data_o
);

  logic     valid_q;
  mice_s2_t data_q, data_d;

  always_comb begin
    logic [8:0]  deg_sum;
    logic [7:0]  min_adj;
    logic [15:0] recip;
    logic [4:0]  q;
    logic [7:0]  rem;
    data_d = '0;
    data_d.p0 = 7'(7'(data_i.digit[0]) * 7'd10 + 7'(data_i.digit[1]));
    data_d.p1 = 7'(7'(data_i.digit[2]) * 7'd10 + 7'(data_i.digit[3]));
    data_d.p2 = 7'(7'(data_i.digit[4]) * 7'd10 + 7'(data_i.digit[5]));

    deg_sum = 9'(data_i.b[0]) + (data_i.offset ? 9'd100 : 9'd0);
    priority if (deg_sum >= 9'd180 && deg_sum <= 9'd189) data_d.deg = 8'(deg_sum - 9'd80);
    else if (deg_sum >= 9'd190 && deg_sum <= 9'd199) data_d.deg = 8'(deg_sum - 9'd190);
    else if (deg_sum > 9'd199) data_d.deg = 8'd199;
    else data_d.deg = deg_sum[7:0];

    min_adj = (data_i.b[1] >= 8'd60) ? data_i.b[1] - 8'd60 : data_i.b[1];
    data_d.min = (min_adj > 8'd59) ? 6'd59 : min_adj[5:0];
    data_d.hun = (data_i.b[2] > 8'd99) ? 7'd99 : data_i.b[2][6:0];

    // divide by ten through the reciprocal 205/2048, exact below 1029
    recip = 16'(data_i.b[4]) * 16'd205;
    q     = recip[15:11];
    rem   = data_i.b[4] - 8'(q) * 8'd10;
    data_d.q = q;
    data_d.r = rem[3:0];

    data_d.b3      = data_i.b[3];
    data_d.b5      = data_i.b[5];
    data_d.south   = data_i.south;
    data_d.west    = data_i.west;
    data_d.msg     = data_i.msg;
    data_d.sym     = data_i.sym;
    data_d.overlay = data_i.overlay;
    data_d.err     = data_i.err;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/mice_finish.sv */
module mice_finish import mice_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  mice_s2_t  data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output mice_out_t data_o
);

  logic      valid_q;
  mice_out_t data_q, data_d;

  always_comb begin
    logic [11:0] spd;
    logic [10:0] crs;
    data_d = '0;
    data_d.lat = 20'(data_i.p0) * 20'd10000 + 20'(data_i.p1) * 20'd100 + 20'(data_i.p2);

    spd = 12'(data_i.b3) * 12'd10 + 12'(data_i.q);
    if (spd >= 12'd800) spd = spd - 12'd800;
    data_d.spd = (spd > 12'd799) ? 10'd799 : spd[9:0];

    crs = 11'(data_i.r) * 11'd100 + 11'(data_i.b5);
    if (crs >= 11'd400) crs = crs - 11'd400;
    data_d.crs = (crs > 11'd599) ? 10'd599 : crs[9:0];

    data_d.south   = data_i.south;
    data_d.deg     = data_i.deg;
    data_d.min     = data_i.min;
    data_d.hun     = data_i.hun;
    data_d.west    = data_i.west;
    data_d.msg     = data_i.msg;
    data_d.sym     = data_i.sym;
    data_d.overlay = data_i.overlay;
    data_d.err     = data_i.err;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/mic_e_position_decoder_core.sv */
// Mic-E position decoder: one packet header (six destination characters, six
// info bytes, symbol code and table) in, one decoded position out. Three
// register stages (classify, combine, finish) accept one item every cycle
// while the output is taken; each stage takes a new item whenever it is
// empty or its successor takes its current one, so idle stages fill up even
// while the output register holds a result that is not yet taken.
module mic_e_position_decoder_core import mice_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // dest_chars[47:0], info_chars[95:48], symbol_code[103:96], symbol_table[111:104]
  input  logic [InWidth-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // lat_ddmmhh[19:0], lat_south[20], lon_degrees[28:21], lon_minutes[34:29],
  // lon_hundredths[41:35], lon_west[42], speed_knots[52:43],
  // course_degrees[62:53], message_code[66:63], symbol_id[74:67],
  // has_overlay[75], format_error[76], zero[79:77]
  output logic [OutWidth-1:0] m_axis_tdata_o
);

  mice_in_t  in_item;
  mice_s1_t  s1_data;
  mice_s2_t  s2_data;
  mice_out_t out_data;
  logic      s1_valid, s1_ready, s2_valid, s2_ready;

  assign in_item.dest      = s_axis_tdata_i[47:0];
  assign in_item.info      = s_axis_tdata_i[95:48];
  assign in_item.sym_code  = s_axis_tdata_i[103:96];
  assign in_item.sym_table = s_axis_tdata_i[111:104];

  mice_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (in_item),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  mice_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  mice_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_data)
  );

  assign m_axis_tdata_o = {3'b000, out_data};

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_valid)
    else $error("accepted item did not reach the first stage");

  a_lat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_data.lat <= 20'd999999)
    else $error("latitude digits out of range");

  a_lon_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_data.deg <= 8'd199 && out_data.min <= 6'd59
                        && out_data.hun <= 7'd99)
    else $error("longitude field out of range");

  a_motion_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_data.spd <= 10'd799 && out_data.crs <= 10'd599
                        && out_data.sym <= SYM_MAX)
    else $error("speed, course or symbol out of range");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mice_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ALT_SYMBOL_BASE = 96;
  localparam int unsigned IDLE_PCT        = 38;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PRINT_LIMIT     = 40;

  typedef struct {
    logic [47:0] dest;
    logic [47:0] info;
    logic [7:0]  code;
    logic [7:0]  tbl;
    bit          typed;
    mice_out_t   want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  // side channel to the monitor, updated together with tdata
  bit        item_typed = 1'b0;
  mice_out_t item_want = '0;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  mice_out_t   pending_q[$];
  stim_row_t   rows[$];
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  mic_e_position_decoder_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mice_out_t decode_position(input logic [InWidth-1:0] word);
    mice_out_t   r;
    mice_kind_e  k;
    logic [7:0]  c;
    logic [7:0]  code;
    logic [7:0]  tbl;
    int unsigned lat, digit, bits, offset, deg, mins, hun, spd, crs, sym;
    int unsigned v [6];
    bit          has_std, has_cus, has_bad, south, west, err;
    r = '0;
    lat = 0;
    bits = 0;
    offset = 0;
    south = 0;
    west = 0;
    err = 0;
    has_std = 0;
    has_cus = 0;
    has_bad = 0;
    for (int i = 0; i < 6; i++) begin
      c = word[47 - 8*i -: 8];
      if ((c >= CH_0 && c <= CH_9) || c == CH_L) k = KIND_DIGIT;
      else if (c >= CH_P && c <= CH_Z) k = KIND_STD;
      else if (c >= CH_A && c <= CH_K) k = KIND_CUS;
      else k = KIND_BAD;
      case (k)
        KIND_DIGIT: digit = (c == CH_L) ? 0 : int'(c) - int'(CH_0);
        KIND_STD:   digit = (int'(c) - int'(CH_P)) % 10;
        KIND_CUS:   digit = (int'(c) - int'(CH_A)) % 10;
        default:    digit = 0;
      endcase
      lat = lat * 10 + digit;
      if (k == KIND_BAD) err = 1;
      if (i < 3) begin
        bits = bits << 1;
        if (k == KIND_STD) begin
          has_std = 1;
          bits = bits | 1;
        end else if (k == KIND_CUS) begin
          has_cus = 1;
          bits = bits | 1;
        end else if (k == KIND_BAD) begin
          has_bad = 1;
        end
      end else begin
        // custom letters are not allowed past the message bits
        if (k == KIND_CUS) err = 1;
        if (i == 3) south = (k == KIND_DIGIT || k == KIND_CUS);
        if (i == 4) offset = (k == KIND_STD) ? 100 : 0;
        if (i == 5) west = (k == KIND_STD);
      end
    end

    if (has_bad || (has_std && has_cus)) r.msg = MSG_INVALID;
    else if (bits == 0) r.msg = MSG_EMERGENCY;
    else if (has_std) r.msg = MSG_STD_BASE - 4'(bits);
    else r.msg = MSG_CUS_BASE - 4'(bits);

    for (int i = 0; i < 6; i++) begin
      c = word[95 - 8*i -: 8];
      if (c < INFO_BIAS) begin
        err = 1;
        v[i] = 0;
      end else begin
        v[i] = int'(c) - int'(INFO_BIAS);
      end
    end

    deg = v[0] + offset;
    if (deg >= 180 && deg <= 189) deg = deg - 80;
    else if (deg >= 190 && deg <= 199) deg = deg - 190;
    if (deg > 199) deg = 199;

    mins = (v[1] >= 60) ? v[1] - 60 : v[1];
    if (mins > 59) mins = 59;

    hun = (v[2] > 99) ? 99 : v[2];

    spd = v[3] * 10 + v[4] / 10;
    if (spd >= 800) spd = spd - 800;
    if (spd > 799) spd = 799;

    crs = (v[4] % 10) * 100 + v[5];
    if (crs >= 400) crs = crs - 400;
    if (crs > 599) crs = 599;

    code = word[103:96];
    tbl  = word[111:104];
    // the alternate table shifts by 96, even for codes below the bias
    if (tbl == CH_SLASH) sym = (code < SYM_BIAS) ? 0 : int'(code) - int'(SYM_BIAS);
    else sym = int'(code) + ALT_SYMBOL_BASE - int'(SYM_BIAS);
    if (sym > SYM_MAX) sym = SYM_MAX;

    r.lat     = lat[19:0];
    r.south   = south;
    r.deg     = deg[7:0];
    r.min     = mins[5:0];
    r.hun     = hun[6:0];
    r.west    = west;
    r.spd     = spd[9:0];
    r.crs     = crs[9:0];
    r.sym     = sym[7:0];
    r.overlay = (tbl != CH_SLASH && tbl != CH_BSLASH);
    r.err     = err;
    return r;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("ERROR result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic compare_fields(input mice_out_t got, input mice_out_t want);
    check_field("lat_ddmmhh", got.lat, want.lat);
    check_field("lat_south", got.south, want.south);
    check_field("lon_degrees", got.deg, want.deg);
    check_field("lon_minutes", got.min, want.min);
    check_field("lon_hundredths", got.hun, want.hun);
    check_field("lon_west", got.west, want.west);
    check_field("speed_knots", got.spd, want.spd);
    check_field("course_degrees", got.crs, want.crs);
    check_field("message_code", got.msg, want.msg);
    check_field("symbol_id", got.sym, want.sym);
    check_field("has_overlay", got.overlay, want.overlay);
    check_field("format_error", got.err, want.err);
  endtask

  function automatic void add_row(input logic [47:0] dest, input logic [47:0] info,
                                  input logic [7:0] code, input logic [7:0] tbl,
                                  input bit typed, input mice_out_t want);
    stim_row_t row;
    row.dest  = dest;
    row.info  = info;
    row.code  = code;
    row.tbl   = tbl;
    row.typed = typed;
    row.want  = want;
    rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_char(input mice_kind_e k);
    case (k)
      KIND_DIGIT: return ($urandom_range(10) == 0) ? CH_L : CH_0 + 8'($urandom_range(9));
      KIND_STD:   return CH_P + 8'($urandom_range(10));
      KIND_CUS:   return CH_A + 8'($urandom_range(10));
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [InWidth-1:0] random_packet();
    logic [127:0] raw;
    logic [47:0]  dest;
    logic [47:0]  info;
    logic [7:0]   code;
    logic [7:0]   tbl;
    mice_kind_e   msg_kind;
    mice_kind_e   k;
    int unsigned  span [6];
    raw = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(99) < 20) return raw[InWidth-1:0];

    // structured header with random content; some characters and bytes stay malformed
    span = '{199, 99, 99, 99, 99, 127};
    msg_kind = mice_kind_e'($urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      if (msg_kind == KIND_BAD) k = mice_kind_e'($urandom_range(3));
      else k = ($urandom_range(1) != 0) ? msg_kind : KIND_DIGIT;
      dest[47 - 8*i -: 8] = pick_char(k);
    end
    for (int i = 3; i < 6; i++) begin
      if ($urandom_range(9) == 0) k = mice_kind_e'($urandom_range(3, 2));
      else k = ($urandom_range(1) != 0) ? KIND_STD : KIND_DIGIT;
      dest[47 - 8*i -: 8] = pick_char(k);
    end
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(11) == 0) info[47 - 8*i -: 8] = 8'($urandom_range(255));
      else info[47 - 8*i -: 8] = INFO_BIAS + 8'($urandom_range(span[i]));
    end
    code = ($urandom_range(3) != 0) ? 8'($urandom_range(126, 33)) : 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       tbl = CH_SLASH;
      1:       tbl = CH_BSLASH;
      2:       tbl = CH_A + 8'($urandom_range(25));
      default: tbl = 8'($urandom_range(255));
    endcase
    return {tbl, code, info, dest};
  endfunction

  task automatic offer_item(input logic [InWidth-1:0] word, input bit typed,
                            input mice_out_t want);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    item_typed    <= typed;
    item_want     <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!idle_on) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // track accepted items and check results in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_q.push_back(item_typed ? item_want : decode_position(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) report_error("result with no item pending");
        else compare_fields(m_axis_tdata[76:0], pending_q.pop_front());
        result_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    add_row("000000", 48'h1C1C1C1C1C1C, "!", CH_SLASH, 1'b1,
            mice_out_t'{south: 1'b1, default: '0});
    add_row(48'h0, 48'h0, 8'h00, 8'h00, 1'b1,
            mice_out_t'{msg: MSG_INVALID, sym: 8'd63, overlay: 1'b1, err: 1'b1, default: '0});
    add_row(48'hFFFFFFFFFFFF, 48'h1C1C1C1C1C1C, 8'hFF, CH_SLASH, 1'b1,
            mice_out_t'{msg: MSG_INVALID, sym: SYM_MAX, err: 1'b1, default: '0});
    add_row(48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 8'hFF, 8'hFF, 1'b0, '0);
    // standard, custom, mixed and unknown message letters
    add_row("PPP000", 48'h1D1E1F202122, "~", CH_BSLASH, 1'b0, '0);
    add_row("PQR0PP", 48'h7C4050606070, "A", CH_SLASH, 1'b0, '0);
    add_row("ABC000", 48'h303132333435, ">", "D", 1'b0, '0);
    add_row("AJK999", 48'h404142434445, "[", CH_SLASH, 1'b0, '0);
    add_row("PA0000", 48'h202020202020, "!", CH_SLASH, 1'b0, '0);
    add_row("0M0000", 48'h202020202020, "!", CH_SLASH, 1'b0, '0);
    // custom letters in the flag positions
    add_row("123A45", 48'h505050505050, "k", CH_SLASH, 1'b0, '0);
    add_row("1234K5", 48'h505050505050, "k", CH_SLASH, 1'b0, '0);
    add_row("12345J", 48'h505050505050, "k", CH_SLASH, 1'b0, '0);
    add_row("LLLLLL", 48'h1C1C1C1C1C1C, "!", CH_SLASH, 1'b0, '0);
    add_row("KZK0Z0", 48'h1C1C1C1C1C1C, "!", CH_SLASH, 1'b0, '0);
    // longitude wraps at 180 and 190, a wrap without offset, and saturation
    add_row("000ZPZ", 48'h6C1C1C1C1C1C, "!", CH_SLASH, 1'b0, '0);
    add_row("000ZPZ", 48'h7B1C1C1C1C1C, "!", CH_SLASH, 1'b0, '0);
    add_row("000Z00", 48'hD51C1C1C1C1C, "!", CH_SLASH, 1'b0, '0);
    add_row("000ZPZ", 48'hFFFF7F1C1C1C, "!", CH_SLASH, 1'b0, '0);
    // info bytes under the bias
    add_row("123456", 48'h1B1C1B1C1B1C, "!", CH_SLASH, 1'b0, '0);
    // speed at 800 wraps, course saturates
    add_row("000000", 48'h1C1C1C6C257F, "!", CH_SLASH, 1'b0, '0);
    add_row("000000", 48'h1C1C1C1C25FF, "!", CH_SLASH, 1'b0, '0);
    // symbol codes below the bias on both tables
    add_row("000000", 48'h1C1C1C1C1C1C, 8'd32, CH_BSLASH, 1'b0, '0);
    add_row("000000", 48'h1C1C1C1C1C1C, 8'd32, CH_SLASH, 1'b0, '0);
    add_row("000000", 48'h1C1C1C1C1C1C, 8'd0, "A", 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      offer_item({rows[i].tbl, rows[i].code, rows[i].info, rows[i].dest},
                 rows[i].typed, rows[i].want);

    repeat (300) offer_item(random_packet(), 1'b0, '0);

    // hold the output while items keep coming, so the pipeline backs up
    hold_req <= 1'b1;
    repeat (80) offer_item(random_packet(), 1'b0, '0);

    // drain completely before going on
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);

    idle_on <= 1'b0;
    repeat (200) offer_item(random_packet(), 1'b0, '0);
    idle_on <= 1'b1;
    repeat (320) offer_item(random_packet(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
    // let the monitor record the last accepted item before draining
    @(posedge clk_i);

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
